[rtl/core/stsch_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// stsch_pkg
// Shared types, codes and constants of the sorted timeout scheduler.
// ----------------------------------------------------------------------------
package stsch_pkg;

    localparam int NUM_SLOTS_DEF = 16;
    localparam logic [15:0] TICK_MAX = 16'hFFFF;

    typedef logic [1:0] cmd_code_t;
    localparam cmd_code_t CMD_TICK    = 2'd0;
    localparam cmd_code_t CMD_REQUEST = 2'd1;
    localparam cmd_code_t CMD_CANCEL  = 2'd2;

    typedef logic [2:0] kind_t;
    localparam kind_t KIND_EXPIRED   = 3'd0;
    localparam kind_t KIND_NO_EXPIRY = 3'd1;
    localparam kind_t KIND_ACCEPTED  = 3'd2;
    localparam kind_t KIND_POOL_FULL = 3'd3;
    localparam kind_t KIND_CANCELLED = 3'd4;
    localparam kind_t KIND_INACTIVE  = 3'd5;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_ARM_RD,
        ST_ARM_REB,
        ST_ARM_SCAN,
        ST_ARM_INS,
        ST_TICK_CHK,
        ST_EMIT,
        ST_CANCEL
    } state_t;

    typedef struct packed {
        logic  accept;
        logic  div_start;
        logic  req_wr;
        logic  arm_rd;
        logic  arm_reb;
        logic  scan_step;
        logic  arm_ins;
        logic  tick_start;
        logic  tick_step;
        logic  emit;
        kind_t emit_kind;
        logic  emit_use_slot;
        logic  cancel_do;
    } stsch_cmd_t;

    typedef struct packed {
        logic list_empty;
        logic pool_full;
        logic head_match;
        logic head_repeat;
        logic have_prev;
        logic out_free;
        logic div_done;
        logic scan_more;
    } stsch_status_t;

endpackage
`default_nettype wire

[rtl/core/stsch_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// stsch_if
// Valid/ready channels for scheduler commands and results.
// ----------------------------------------------------------------------------
interface stsch_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic        repeat_req;
    logic [15:0] period_ms;
    logic [3:0]  handle;

    modport source (output valid, cmd, repeat_req, period_ms, handle, input ready);
    modport sink   (input valid, cmd, repeat_req, period_ms, handle, output ready);
endinterface

interface stsch_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [3:0] slot;
    logic [4:0] high_water;
    logic       last;

    modport source (output valid, kind, slot, high_water, last, input ready);
    modport sink   (input valid, kind, slot, high_water, last, output ready);
endinterface
`default_nettype wire

[rtl/core/stsch_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// stsch_div
// Restoring divider, one quotient bit per cycle, 17-bit by 8-bit.
// ----------------------------------------------------------------------------
module stsch_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [16:0] num,
    input  wire logic [7:0]  den,
    output logic             done,
    output logic [16:0]      quo
);
    localparam int NUM_W = 17;
    localparam logic [4:0] LAST_BIT = 5'(NUM_W - 1);

    logic [16:0] num_reg;
    logic [7:0]  rem_reg, rem_next;
    logic [7:0]  den_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [8:0]  trial;
    logic        ge;

    always_comb
    begin
        trial    = {rem_reg, num_reg[NUM_W-1]};
        ge       = trial >= {1'b0, den_reg};
        rem_next = ge ? 8'(trial - {1'b0, den_reg}) : trial[7:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == LAST_BIT)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[NUM_W-2:0], ge};
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign quo  = num_reg;
endmodule
`default_nettype wire

[rtl/core/stsch_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// stsch_ctrl
// Sequencer for tick, request and cancel handling.
// ----------------------------------------------------------------------------
module stsch_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    input  wire logic [1:0]             in_cmd,
    output logic                        in_ready,
    input  wire stsch_pkg::stsch_status_t sts,
    output stsch_pkg::stsch_cmd_t       cmd
);
    import stsch_pkg::*;

    state_t state_reg, state_next;
    logic   arm_tick_reg, arm_tick_next;
    kind_t  kind_reg, kind_next;
    logic   use_slot_reg, use_slot_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            arm_tick_reg <= 1'b0;
            kind_reg     <= KIND_NO_EXPIRY;
            use_slot_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            arm_tick_reg <= arm_tick_next;
            kind_reg     <= kind_next;
            use_slot_reg <= use_slot_next;
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        arm_tick_next     = arm_tick_reg;
        kind_next         = kind_reg;
        use_slot_next     = use_slot_reg;
        cmd               = '0;
        cmd.emit_kind     = kind_reg;
        cmd.emit_use_slot = use_slot_reg;
        in_ready          = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    case (in_cmd)
                        CMD_TICK:
                        begin
                            if (sts.list_empty)
                            begin
                                kind_next     = KIND_NO_EXPIRY;
                                use_slot_next = 1'b0;
                                state_next    = ST_EMIT;
                            end
                            else
                            begin
                                cmd.tick_start = 1'b1;
                                state_next     = ST_TICK_CHK;
                            end
                        end
                        CMD_REQUEST:
                        begin
                            if (sts.pool_full)
                            begin
                                kind_next     = KIND_POOL_FULL;
                                use_slot_next = 1'b0;
                                state_next    = ST_EMIT;
                            end
                            else
                            begin
                                cmd.div_start = 1'b1;
                                state_next    = ST_DIV;
                            end
                        end
                        CMD_CANCEL:
                        begin
                            state_next = ST_CANCEL;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_DIV:
            begin
                if (sts.div_done)
                begin
                    cmd.req_wr    = 1'b1;
                    arm_tick_next = 1'b0;
                    state_next    = ST_ARM_RD;
                end
            end
            ST_ARM_RD:
            begin
                cmd.arm_rd = 1'b1;
                state_next = ST_ARM_REB;
            end
            ST_ARM_REB:
            begin
                cmd.arm_reb = 1'b1;
                state_next  = ST_ARM_SCAN;
            end
            ST_ARM_SCAN:
            begin
                if (sts.scan_more)
                begin
                    cmd.scan_step = 1'b1;
                end
                else
                begin
                    state_next = ST_ARM_INS;
                end
            end
            ST_ARM_INS:
            begin
                cmd.arm_ins = 1'b1;
                if (arm_tick_reg)
                begin
                    state_next = ST_TICK_CHK;
                end
                else
                begin
                    kind_next     = KIND_ACCEPTED;
                    use_slot_next = 1'b1;
                    state_next    = ST_EMIT;
                end
            end
            ST_TICK_CHK:
            begin
                // The previous expiry is held back until it is known whether
                // another one follows, so that its last flag is right.
                if (sts.out_free)
                begin
                    cmd.tick_step = 1'b1;
                    if (sts.head_match)
                    begin
                        if (sts.head_repeat)
                        begin
                            arm_tick_next = 1'b1;
                            state_next    = ST_ARM_RD;
                        end
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_CANCEL:
            begin
                if (sts.out_free)
                begin
                    cmd.cancel_do = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

[rtl/core/stsch_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// stsch_dp
// Slot pool, deadline-ordered list, tick counter and result register.
// ----------------------------------------------------------------------------
module stsch_dp #(
    parameter int NUM_SLOTS = stsch_pkg::NUM_SLOTS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [7:0]           cfg_wdata,
    input  wire logic                 in_repeat_req,
    input  wire logic [15:0]          in_period_ms,
    input  wire logic [3:0]           in_handle,
    input  wire stsch_pkg::stsch_cmd_t cmd,
    output stsch_pkg::stsch_status_t  sts,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [2:0]                out_kind,
    output logic [3:0]                out_slot,
    output logic [4:0]                out_high_water,
    output logic                      out_last
);
    import stsch_pkg::*;

    localparam int SW = $clog2(NUM_SLOTS);
    localparam int CW = $clog2(NUM_SLOTS + 1);
    localparam logic [CW-1:0] FULL_LEN = CW'(NUM_SLOTS);

    logic [7:0]    mpt_reg;
    logic [15:0]   count_reg;
    logic [NUM_SLOTS-1:0] active_reg;
    logic [NUM_SLOTS-1:0] rep_reg;
    logic [15:0]   period_mem [NUM_SLOTS];
    logic [SW-1:0] ord_slot [NUM_SLOTS];
    logic [15:0]   ord_dl [NUM_SLOTS];
    logic [CW-1:0] len_reg;
    logic [CW-1:0] peak_reg;
    logic [CW-1:0] n_reg;
    logic          have_prev_reg;
    logic [SW-1:0] cur_reg;
    logic [15:0]   per_reg;
    logic [15:0]   dl_reg;
    logic [CW-1:0] pos_reg;
    logic          rep_in_reg;
    logic [3:0]    hdl_reg;
    logic          out_valid_reg;
    kind_t         out_kind_reg;
    logic [3:0]    out_slot_reg;
    logic [4:0]    out_hw_reg;
    logic          out_last_reg;

    logic [SW-1:0] free_idx;
    logic [SW-1:0] head_slot;
    logic          head_match;
    logic          out_free;
    logic [SW-1:0] hdl_idx;
    logic          cancel_ok;
    logic [SW-1:0] cpos;
    logic          cfound;
    logic [SW-1:0] pos_idx;
    logic          reb;
    logic [7:0]    div_den;
    logic [16:0]   div_num;
    logic          div_done;
    logic [16:0]   div_quo;
    logic [15:0]   ticks;
    logic [CW-1:0] cur_plus;
    logic          do_remove;
    logic [SW-1:0] rm_pos;
    logic          do_insert;
    logic          do_emit;
    kind_t         emit_kind;
    logic [3:0]    emit_slot;

    // Period conversion rounds to nearest; a zero divisor counts as one.
    assign div_den = (mpt_reg == 8'd0) ? 8'd1 : mpt_reg;
    assign div_num = {1'b0, in_period_ms} + {10'd0, div_den[7:1]};

    stsch_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    always_comb
    begin
        free_idx = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (!active_reg[i])
            begin
                free_idx = SW'(i);
            end
        end
    end

    always_comb
    begin
        cfound = 1'b0;
        cpos   = '0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            if (!cfound && (CW'(i) < len_reg) && (ord_slot[i] == hdl_idx))
            begin
                cfound = 1'b1;
                cpos   = SW'(i);
            end
        end
    end

    assign head_slot  = ord_slot[0];
    assign head_match = (len_reg != '0) && (ord_dl[0] == count_reg) && (n_reg < FULL_LEN);
    assign out_free   = !out_valid_reg || out_ready;
    assign hdl_idx    = SW'(hdl_reg);
    assign cancel_ok  = (32'(hdl_reg) < NUM_SLOTS) && active_reg[hdl_idx];
    assign pos_idx    = pos_reg[SW-1:0];
    assign reb        = ({1'b0, per_reg} + {1'b0, count_reg}) > {1'b0, TICK_MAX};
    assign ticks      = (div_quo == 17'd0) ? 16'd1 : div_quo[15:0];
    assign cur_plus   = CW'(cur_reg) + CW'(1);

    always_comb
    begin
        sts.list_empty  = (len_reg == '0);
        sts.pool_full   = &active_reg;
        sts.head_match  = head_match;
        sts.head_repeat = rep_reg[head_slot];
        sts.have_prev   = have_prev_reg;
        sts.out_free    = out_free;
        sts.div_done    = div_done;
        sts.scan_more   = (pos_reg < len_reg) ? (ord_dl[pos_idx] <= dl_reg) : 1'b0;
    end

    always_comb
    begin
        do_remove = 1'b0;
        rm_pos    = '0;
        if (cmd.tick_step && head_match)
        begin
            do_remove = 1'b1;
        end
        else if (cmd.cancel_do && cancel_ok && cfound)
        begin
            do_remove = 1'b1;
            rm_pos    = cpos;
        end
        do_insert = cmd.arm_ins && (len_reg < FULL_LEN);
    end

    always_comb
    begin
        do_emit   = 1'b0;
        emit_kind = cmd.emit_kind;
        emit_slot = '0;
        if (cmd.emit)
        begin
            do_emit   = 1'b1;
            emit_slot = cmd.emit_use_slot ? 4'(cur_reg) : 4'd0;
        end
        else if (cmd.tick_step)
        begin
            if (have_prev_reg)
            begin
                do_emit   = 1'b1;
                emit_kind = KIND_EXPIRED;
                emit_slot = 4'(cur_reg);
            end
            else if (!head_match)
            begin
                do_emit   = 1'b1;
                emit_kind = KIND_NO_EXPIRY;
            end
        end
        else if (cmd.cancel_do)
        begin
            do_emit   = 1'b1;
            emit_kind = cancel_ok ? KIND_CANCELLED : KIND_INACTIVE;
            emit_slot = cancel_ok ? hdl_reg : 4'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mpt_reg       <= 8'd1;
            count_reg     <= '0;
            active_reg    <= '0;
            len_reg       <= '0;
            peak_reg      <= '0;
            n_reg         <= '0;
            have_prev_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                mpt_reg <= cfg_wdata;
            end
            if (do_emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.tick_start)
            begin
                count_reg     <= count_reg + 16'd1;
                n_reg         <= '0;
                have_prev_reg <= 1'b0;
            end
            if (cmd.tick_step && head_match)
            begin
                active_reg[head_slot] <= 1'b0;
                n_reg                 <= n_reg + CW'(1);
                have_prev_reg         <= 1'b1;
            end
            if (cmd.cancel_do && cancel_ok)
            begin
                active_reg[hdl_idx] <= 1'b0;
            end
            if (cmd.req_wr && (cur_plus > peak_reg))
            begin
                peak_reg <= cur_plus;
            end
            if (cmd.arm_reb && reb)
            begin
                count_reg <= '0;
            end
            if (do_remove)
            begin
                len_reg <= len_reg - CW'(1);
            end
            else if (do_insert)
            begin
                len_reg             <= len_reg + CW'(1);
                active_reg[cur_reg] <= 1'b1;
            end
        end
    end

    // Ordered list: entry 0 is the earliest deadline.
    always_ff @(posedge clk)
    begin
        if (do_remove)
        begin
            for (int i = 0; i < NUM_SLOTS - 1; i++)
            begin
                if (i >= int'(rm_pos))
                begin
                    ord_slot[i] <= ord_slot[i+1];
                    ord_dl[i]   <= ord_dl[i+1];
                end
            end
        end
        else if (do_insert)
        begin
            for (int i = 1; i < NUM_SLOTS; i++)
            begin
                if (i > int'(pos_idx))
                begin
                    ord_slot[i] <= ord_slot[i-1];
                    ord_dl[i]   <= ord_dl[i-1];
                end
            end
            ord_slot[pos_idx] <= cur_reg;
            ord_dl[pos_idx]   <= dl_reg;
        end
        else if (cmd.arm_reb && reb)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                if (CW'(i) < len_reg)
                begin
                    ord_dl[i] <= ord_dl[i] - count_reg;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.req_wr)
        begin
            period_mem[cur_reg] <= ticks;
        end
        if (cmd.arm_rd)
        begin
            per_reg <= period_mem[cur_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            rep_in_reg <= in_repeat_req;
            hdl_reg    <= in_handle;
        end
        if (cmd.div_start)
        begin
            cur_reg <= free_idx;
        end
        if (cmd.req_wr)
        begin
            rep_reg[cur_reg] <= rep_in_reg;
        end
        if (cmd.tick_step && head_match)
        begin
            cur_reg <= head_slot;
        end
        if (cmd.arm_reb)
        begin
            dl_reg  <= reb ? per_reg : per_reg + count_reg;
            pos_reg <= '0;
        end
        if (cmd.scan_step)
        begin
            pos_reg <= pos_reg + CW'(1);
        end
        if (do_emit)
        begin
            out_kind_reg <= emit_kind;
            out_slot_reg <= emit_slot;
            out_hw_reg   <= 5'(peak_reg);
            out_last_reg <= !(cmd.tick_step && have_prev_reg && head_match);
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_kind       = out_kind_reg;
    assign out_slot       = out_slot_reg;
    assign out_high_water = out_hw_reg;
    assign out_last       = out_last_reg;
endmodule
`default_nettype wire

[rtl/core/sorted_timeout_scheduler_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_timeout_scheduler_unit
// Timeout slot pool kept in deadline order, with tick, request and cancel.
// ----------------------------------------------------------------------------
// A request converts its period in the serial divider, then scans the ordered
// list one entry per cycle over the pending entries up to its place and inserts
// there. A tick removes each expired head and re-arms each repeating slot with a
// scan and insert as for a request. One command is in work at a time.
// Reset clears the counter, list length, peak and active flags at once;
// no clearing pass is needed.
module sorted_timeout_scheduler_unit #(
    parameter int NUM_SLOTS = stsch_pkg::NUM_SLOTS_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [7:0] cfg_wdata,
    stsch_in_if.sink        in_ch,
    stsch_out_if.source     out_ch
);
    import stsch_pkg::*;

    stsch_cmd_t    cmd;
    stsch_status_t sts;
    logic          in_ready;

    stsch_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_cmd   (in_ch.cmd),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    stsch_dp #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .in_repeat_req  (in_ch.repeat_req),
        .in_period_ms   (in_ch.period_ms),
        .in_handle      (in_ch.handle),
        .cmd            (cmd),
        .sts            (sts),
        .out_valid      (out_ch.valid),
        .out_ready      (out_ch.ready),
        .out_kind       (out_ch.kind),
        .out_slot       (out_ch.slot),
        .out_high_water (out_ch.high_water),
        .out_last       (out_ch.last)
    );

    assign in_ch.ready = in_ready;
endmodule
`default_nettype wire
